@@ sv/lru_page_replacement_macros.svh @@
// assertion macros used by the lru page replacement checker
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/lru_pkg.sv @@
// shared constants and types for the lru page replacement block
package lru_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_WIDTH = 16;
    localparam int OCC_W      = $clog2(FRAMES + 1);
    localparam int CFG_W      = 4;
    localparam int CMP_W      = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int COUNT_W    = 32;

    typedef logic [PAGE_WIDTH-1:0] page_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic fire;
        logic hit;
        logic grow;
    } ctl_t;

endpackage

@@ sv/lru_cell.sv @@
// one stack cell: holds a page, compares it, and takes its upper neighbor on a shift
module lru_cell (
    input  logic                     clk,
    input  lru_pkg::page_t           page,
    input  lru_pkg::page_t           prev_entry,
    input  logic [lru_pkg::OCC_W-1:0] cell_index,
    input  logic [lru_pkg::OCC_W-1:0] occ,
    input  lru_pkg::ctl_t            ctl,
    input  logic                     found_in,
    output lru_pkg::page_t           entry,
    output logic                     found_out
);
    import lru_pkg::*;

    page_t entry_reg;
    page_t entry_next;
    logic  occupied;
    logic  match;
    logic  shift;

    // compare against the reference, pass the hit flag down the row
    assign occupied  = cell_index < occ;
    assign match     = occupied && (entry_reg == page);
    assign found_out = found_in | match;

    // cells at or above the moved slot take their neighbor's page
    always_comb
    begin
        if (ctl.hit)
        begin
            shift = !found_in;
        end
        else if (ctl.grow)
        begin
            shift = cell_index <= occ;
        end
        else
        begin
            shift = cell_index < occ;
        end
        entry_next = (ctl.fire && shift) ? prev_entry : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ sv/lru_page_replacement.sv @@
// top level of the lru page replacement block: cell row, occupancy, fault count, result register
//
//  channel   signals                                           direction
//  in        in_valid, in_ready, page_number                   beat in
//  out       out_valid, out_ready, fault, evicted_valid,       beat out
//            evicted_page, resident_count, fault_total
//  cfg       cfg_write_en, cfg_write_data                      write only
//
//  one reference per clock while in_ready is high; result appears the cycle after acceptance
//  the path is the compare chain down the row of FRAMES cells plus the shift select
//  reset clears occupancy, fault count and out_valid and sets frames_reg to 8
//  in_ready drops only while a result is held and out_ready is low
module lru_page_replacement (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [lru_pkg::CFG_W-1:0]  cfg_write_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [15:0]                page_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       fault,
    output logic                       evicted_valid,
    output logic [15:0]                evicted_page,
    output logic [3:0]                 resident_count,
    output logic [31:0]                fault_total
);
    import lru_pkg::*;

    logic [CFG_W-1:0]   frames_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [COUNT_W-1:0] fault_cnt_reg;
    logic [COUNT_W-1:0] fault_cnt_next;
    logic               out_valid_reg;
    logic               fault_reg;
    logic               evicted_valid_reg;
    page_t              evicted_page_reg;
    page_t              evicted_page_next;

    page_t              page;
    page_t              entries [FRAMES];
    logic               found_chain [FRAMES+1];
    logic [CMP_W-1:0]   limit;
    ctl_t               ctl;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign page     = page_number[PAGE_WIDTH-1:0];

    // usable frame count, clamped to one through FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (CMP_W'(frames_reg) > CMP_W'(FRAMES))
        begin
            limit = CMP_W'(FRAMES);
        end
        else
        begin
            limit = CMP_W'(frames_reg);
        end
    end

    // broadcast control
    assign ctl.fire = in_valid && in_ready;
    assign ctl.hit  = found_chain[FRAMES];
    assign ctl.grow = CMP_W'(occ_reg) < limit;

    // row of cells
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lru_cell u_cell (
            .clk        (clk),
            .page       (page),
            .prev_entry ((i == 0) ? page : entries[(i == 0) ? 0 : i - 1]),
            .cell_index (OCC_W'(i)),
            .occ        (occ_reg),
            .ctl        (ctl),
            .found_in   (found_chain[i]),
            .entry      (entries[i]),
            .found_out  (found_chain[i+1])
        );
    end

    // bottom entry leaves on an eviction
    always_comb
    begin
        evicted_page_next = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (OCC_W'(i + 1) == occ_reg)
            begin
                evicted_page_next = evicted_page_next | entries[i];
            end
        end
    end

    // occupancy and fault count
    always_comb
    begin
        occ_next       = occ_reg;
        fault_cnt_next = fault_cnt_reg;
        if (ctl.fire && !ctl.hit)
        begin
            fault_cnt_next = fault_cnt_reg + COUNT_W'(1);
            if (ctl.grow)
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= CFG_W'(8);
            occ_reg       <= '0;
            fault_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                frames_reg <= cfg_write_data;
            end
            occ_reg       <= occ_next;
            fault_cnt_reg <= fault_cnt_next;
            if (ctl.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            fault_reg         <= !ctl.hit;
            evicted_valid_reg <= !ctl.hit && !ctl.grow;
            evicted_page_reg  <= (!ctl.hit && !ctl.grow) ? evicted_page_next : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fault          = fault_reg;
    assign evicted_valid  = evicted_valid_reg;
    assign evicted_page   = evicted_page_reg;
    assign resident_count = 4'(occ_reg);
    assign fault_total    = fault_cnt_reg;

endmodule

@@ sv/lru_chk.sv @@
// port-level checker for the lru page replacement block, with its bind
`include "lru_page_replacement_macros.svh"

module lru_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        fault,
    input logic        evicted_valid,
    input logic [15:0] evicted_page
);

    // an eviction only happens on a fault
    `LRU_ASSERT_IMPLY(a_evict_needs_fault, clk, rst_n, out_valid && evicted_valid, fault)

    // a result without an eviction reports page zero
    `LRU_ASSERT_IMPLY(a_evict_page_zero, clk, rst_n, out_valid && !evicted_valid, evicted_page == 16'd0)

    // an accepted reference shows its result on the next cycle
    `LRU_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

    // a stalled result holds
    `LRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(evicted_page))

endmodule

bind lru_page_replacement lru_chk u_lru_chk (.*);
